// File: src/shl_pkg.sv
`timescale 1ns / 1ps

package shl_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int OP_W       = 2;
  localparam int NAME_W     = 64;
  localparam int IDX_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 10;
  // Widest slot number the table can need (up to 4096 slots).
  localparam int SLOT_MAX_W = 12;
  // Width used for index sums against the user area limits.
  localparam int SUM_W      = 13;
  localparam int HASH_W     = 16;

  // Operation codes of a request.
  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_PERM   = 2'd2;

  // Status codes of a result.
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_APPEND,
    CMD_PERM,
    CMD_BAD
  } cmd_kind_t;

  // A classified request, passed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t              kind;
    logic [NAME_W-1:0]      name;
    logic [IDX_W-1:0]       eidx;
    logic [SLOT_MAX_W-1:0]  start;
    logic [SLOT_MAX_W-1:0]  step;
  } cmd_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_HASH,
    FR_DIV1,
    FR_MOD1,
    FR_DIV2,
    FR_MOD2,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE,
    BK_SLOT,
    BK_CMP,
    BK_APPEND,
    BK_DONE
  } bk_state_t;

endpackage

// File: src/shl_in_if.sv
`timescale 1ns / 1ps

interface shl_in_if;
  logic                        valid;
  logic                        ready;
  logic [shl_pkg::OP_W-1:0]    op;
  logic [shl_pkg::NAME_W-1:0]  name;
  logic [shl_pkg::IDX_W-1:0]   entry_index;

  modport source (output valid, output op, output name, output entry_index, input ready);
  modport sink   (input valid, input op, input name, input entry_index, output ready);
endinterface

// File: src/shl_out_if.sv
`timescale 1ns / 1ps

interface shl_out_if;
  logic                          valid;
  logic                          ready;
  logic [shl_pkg::STATUS_W-1:0]  status;
  logic [shl_pkg::IDX_W-1:0]     symbol_index;
  logic                          is_user;
  logic [shl_pkg::IDX_W-1:0]     region_offset;

  modport source (output valid, output status, output symbol_index, output is_user,
                  output region_offset, input ready);
  modport sink   (input valid, input status, input symbol_index, input is_user,
                  input region_offset, output ready);
endinterface

// File: src/symbol_hash_lookup_insert_top.sv
`timescale 1ns / 1ps

// Symbol table engine: looks up and enters names of up to eight bytes in a
// double-hashed, open-addressed table of hash slots.
// The in_chan channel carries one request (op, name, entry_index) and the
// out_chan channel returns exactly one result (status, symbol_index, is_user,
// region_offset) per request, in request order. Both use valid/ready.
// The cfg_we/cfg_wdata port sets the first user entry; write it only while
// no request is in flight.
// A front end hashes the name and derives the start slot and probe step,
// taking one request at a time; a two-entry queue then hands the request to
// the back end, which walks the slot memory. Each probe passes a probe and a
// slot state, plus a compare state when the slot is occupied and the stored
// name must be read and compared; a permanent entry skips the compare.
// After reset the back end clears all hash slots, one per cycle; no request
// is accepted during that pass, though configuration writes are taken.
// When the receiver stalls, the result waits in the output register while
// the front end keeps accepting and hashing requests until the queue fills.
module symbol_hash_lookup_insert_top #(
  parameter int TABLE_SIZE  = 1553,
  parameter int USER_LIMIT  = 1500,
  parameter int ENTRY_COUNT = 2048
) (
  input  logic                       clk,
  input  logic                       rst_n,
  shl_in_if.sink                     in_chan,
  shl_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [shl_pkg::CFG_W-1:0]  cfg_wdata
);

  // First user entry; permanent entries are meant to live below it (not enforced).
  logic [shl_pkg::CFG_W-1:0] user_start_r;

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  logic          clearing;
  shl_pkg::cmd_t push_cmd;
  shl_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_start_r <= '0;
    end else if (cfg_we) begin
      user_start_r <= cfg_wdata;
    end
  end

  // The front end holds off new requests while the slot clearing pass runs.
  shl_front #(
    .TABLE_SIZE  (TABLE_SIZE),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .hold    (clearing),
    .full    (full),
    .push    (push),
    .cmd     (push_cmd)
  );

  shl_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // The back end owns both memories, the user entry counter and the result
  // register that drives out_chan.
  shl_back #(
    .TABLE_SIZE  (TABLE_SIZE),
    .USER_LIMIT  (USER_LIMIT),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .user_start (user_start_r),
    .empty      (empty),
    .cmd        (pop_cmd),
    .pop        (pop),
    .clearing   (clearing),
    .out_chan   (out_chan)
  );

endmodule

// File: src/shl_ram.sv
`timescale 1ns / 1ps

module shl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/shl_front.sv
`timescale 1ns / 1ps

module shl_front #(
  parameter int TABLE_SIZE  = 1553,
  parameter int ENTRY_COUNT = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  shl_in_if.sink            in_chan,
  input  logic              hold,
  input  logic              full,
  output logic              push,
  output shl_pkg::cmd_t     cmd
);

  localparam int HW = shl_pkg::HASH_W;
  localparam int PW = HW + 32;
  // Rounded-up reciprocal; exact quotients for any 16-bit dividend.
  localparam longint unsigned RECIP_L =
    ((64'd1 << 32) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [31:0] RECIP = 32'(RECIP_L);

  function automatic logic [shl_pkg::NAME_W-1:0] cut_name(input logic [shl_pkg::NAME_W-1:0] nm);
    logic [shl_pkg::NAME_W-1:0] keep;
    logic                       stop;
    keep = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (nm[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) keep[8*i +: 8] = nm[8*i +: 8];
    end
    return keep;
  endfunction

  function automatic logic [HW-1:0] name_hash(input logic [shl_pkg::NAME_W-1:0] nm);
    logic [HW-1:0] h;
    logic          stop;
    h = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (nm[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) begin
        h = h + {8'd0, nm[8*i +: 8]};
        h = {h[7:0], h[15:8]};
      end
    end
    return h;
  endfunction

  shl_pkg::fr_state_t state_r, state_nxt;

  logic [shl_pkg::OP_W-1:0]       op_r;
  logic [shl_pkg::NAME_W-1:0]     name_r;
  logic [shl_pkg::IDX_W-1:0]      eidx_r;
  logic [HW-1:0]                  x_r;
  logic [PW-1:0]                  prod_r;
  logic [shl_pkg::SLOT_MAX_W-1:0] start_r;
  logic [shl_pkg::SLOT_MAX_W-1:0] step_r;

  logic [HW-1:0] quo;
  logic [HW-1:0] rem;
  logic          accept;

  // Remainder from the registered quotient: one constant multiply and a subtract.
  assign quo = prod_r[PW-1 -: HW];
  assign rem = x_r - HW'(32'(quo) * 32'(TABLE_SIZE));

  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shl_pkg::FR_IDLE: if (accept) state_nxt = shl_pkg::FR_HASH;
      shl_pkg::FR_HASH: state_nxt = shl_pkg::FR_DIV1;
      shl_pkg::FR_DIV1: state_nxt = shl_pkg::FR_MOD1;
      shl_pkg::FR_MOD1: state_nxt = shl_pkg::FR_DIV2;
      shl_pkg::FR_DIV2: state_nxt = shl_pkg::FR_MOD2;
      shl_pkg::FR_MOD2: state_nxt = shl_pkg::FR_PUSH;
      shl_pkg::FR_PUSH: if (!full) state_nxt = shl_pkg::FR_IDLE;
      default:          state_nxt = shl_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == shl_pkg::FR_IDLE) && !hold;
    push          = (state_r == shl_pkg::FR_PUSH) && !full;
  end

  always_comb begin
    cmd.name  = name_r;
    cmd.eidx  = eidx_r;
    cmd.start = start_r;
    cmd.step  = step_r;
    unique case (op_r)
      shl_pkg::OP_FIND:   cmd.kind = shl_pkg::CMD_LOOKUP;
      shl_pkg::OP_APPEND: cmd.kind = shl_pkg::CMD_APPEND;
      shl_pkg::OP_PERM: begin
        if (shl_pkg::SUM_W'(eidx_r) >= shl_pkg::SUM_W'(ENTRY_COUNT)) begin
          cmd.kind = shl_pkg::CMD_BAD;
        end else begin
          cmd.kind = shl_pkg::CMD_PERM;
        end
      end
      default:            cmd.kind = shl_pkg::CMD_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shl_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      shl_pkg::FR_IDLE: begin
        if (accept) begin
          op_r   <= in_chan.op;
          name_r <= in_chan.name;
          eidx_r <= in_chan.entry_index;
        end
      end
      shl_pkg::FR_HASH: begin
        name_r <= cut_name(name_r);
        x_r    <= name_hash(name_r);
      end
      shl_pkg::FR_DIV1, shl_pkg::FR_DIV2: begin
        prod_r <= PW'(x_r) * PW'(RECIP);
      end
      shl_pkg::FR_MOD1: begin
        start_r <= shl_pkg::SLOT_MAX_W'(rem);
        x_r     <= quo;
      end
      shl_pkg::FR_MOD2: begin
        step_r <= shl_pkg::SLOT_MAX_W'(rem);
      end
      shl_pkg::FR_PUSH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/shl_cmd_queue.sv
`timescale 1ns / 1ps

module shl_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  shl_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output shl_pkg::cmd_t  pop_cmd,
  output logic           empty
);

  shl_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: src/shl_back.sv
`timescale 1ns / 1ps

module shl_back #(
  parameter int TABLE_SIZE  = 1553,
  parameter int USER_LIMIT  = 1500,
  parameter int ENTRY_COUNT = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [shl_pkg::CFG_W-1:0]   user_start,
  input  logic                        empty,
  input  shl_pkg::cmd_t               cmd,
  output logic                        pop,
  output logic                        clearing,
  shl_out_if.source                   out_chan
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int EIDX_W = $clog2(ENTRY_COUNT);
  localparam int UCNT_W = $clog2(USER_LIMIT + 1);
  localparam int PCNT_W = $clog2(TABLE_SIZE + 1);
  localparam int SUM_W  = shl_pkg::SUM_W;
  localparam int IDX_W  = shl_pkg::IDX_W;

  shl_pkg::bk_state_t state_r, state_nxt;

  shl_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]            p_r, p_nxt;
  logic [PCNT_W-1:0]            n_r, n_nxt;
  logic [SLOT_W-1:0]            clr_r, clr_nxt;
  logic [EIDX_W-1:0]            entry_r, entry_nxt;
  logic [UCNT_W-1:0]            ucnt_r, ucnt_nxt;
  logic [shl_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [EIDX_W-1:0]            res_idx_r, res_idx_nxt;
  logic                         res_ok_r, res_ok_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [shl_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]             out_index_r, out_index_nxt;
  logic                         out_user_r, out_user_nxt;
  logic [IDX_W-1:0]             out_offset_r, out_offset_nxt;

  logic                         slot_we;
  logic [SLOT_W-1:0]            slot_waddr;
  logic [EIDX_W:0]              slot_wdata;
  logic [SLOT_W-1:0]            slot_raddr;
  logic [EIDX_W:0]              slot_rdata;
  logic                         name_we;
  logic [EIDX_W-1:0]            name_waddr;
  logic [shl_pkg::NAME_W-1:0]   name_rdata;
  logic [EIDX_W-1:0]            name_raddr;

  logic [SLOT_W-1:0]            step;
  logic [SLOT_W-1:0]            p_step;
  logic [SUM_W-1:0]             usum;
  logic                         room;
  logic [EIDX_W-1:0]            uidx;
  logic [EIDX_W-1:0]            perm_idx;
  logic                         slot_used;
  logic [EIDX_W-1:0]            slot_entry;
  logic                         can_emit;
  logic [SUM_W-1:0]             ix_ext;
  logic [SUM_W-1:0]             us_ext;
  logic                         in_user;

  // Slot word: used flag on top, entry index below.
  shl_ram #(.WIDTH(EIDX_W + 1), .DEPTH(TABLE_SIZE)) u_slots (
    .clk     (clk),
    .we      (slot_we),
    .waddr   (slot_waddr),
    .wdata   (slot_wdata),
    .raddr   (slot_raddr),
    .rd_data (slot_rdata)
  );

  shl_ram #(.WIDTH(shl_pkg::NAME_W), .DEPTH(ENTRY_COUNT)) u_names (
    .clk     (clk),
    .we      (name_we),
    .waddr   (name_waddr),
    .wdata   (cmd_r.name),
    .raddr   (name_raddr),
    .rd_data (name_rdata)
  );

  // Step back by the probe step, wrapping modulo the table size.
  assign step   = cmd_r.step[SLOT_W-1:0];
  assign p_step = (p_r >= step) ? (p_r - step) : (p_r + SLOT_W'(TABLE_SIZE) - step);

  assign usum     = SUM_W'(user_start) + SUM_W'(ucnt_r);
  assign room     = (ucnt_r < UCNT_W'(USER_LIMIT)) && (usum < SUM_W'(ENTRY_COUNT));
  assign uidx     = EIDX_W'(usum);
  assign perm_idx = EIDX_W'(cmd_r.eidx);

  assign slot_used  = slot_rdata[EIDX_W];
  assign slot_entry = slot_rdata[EIDX_W-1:0];

  assign can_emit = !out_valid_r || out_chan.ready;
  assign ix_ext   = SUM_W'(res_idx_r);
  assign us_ext   = SUM_W'(user_start);
  assign in_user  = ix_ext >= us_ext;

  assign clearing = (state_r == shl_pkg::BK_CLEAR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shl_pkg::BK_CLEAR: begin
        if (clr_r == SLOT_W'(TABLE_SIZE - 1)) state_nxt = shl_pkg::BK_IDLE;
      end
      shl_pkg::BK_IDLE: begin
        if (!empty) begin
          unique case (cmd.kind)
            shl_pkg::CMD_LOOKUP, shl_pkg::CMD_PERM: state_nxt = shl_pkg::BK_PROBE;
            shl_pkg::CMD_APPEND:                    state_nxt = shl_pkg::BK_APPEND;
            default:                                state_nxt = shl_pkg::BK_DONE;
          endcase
        end
      end
      shl_pkg::BK_PROBE: begin
        if (n_r == PCNT_W'(TABLE_SIZE)) begin
          state_nxt = shl_pkg::BK_DONE;
        end else begin
          state_nxt = shl_pkg::BK_SLOT;
        end
      end
      shl_pkg::BK_SLOT: begin
        if (!slot_used) begin
          state_nxt = shl_pkg::BK_DONE;
        end else if (cmd_r.kind == shl_pkg::CMD_PERM) begin
          state_nxt = shl_pkg::BK_PROBE;
        end else begin
          state_nxt = shl_pkg::BK_CMP;
        end
      end
      shl_pkg::BK_CMP: begin
        if (name_rdata == cmd_r.name) begin
          state_nxt = shl_pkg::BK_DONE;
        end else begin
          state_nxt = shl_pkg::BK_PROBE;
        end
      end
      shl_pkg::BK_APPEND: state_nxt = shl_pkg::BK_DONE;
      shl_pkg::BK_DONE:   if (can_emit) state_nxt = shl_pkg::BK_IDLE;
      default:            state_nxt = shl_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    slot_we        = 1'b0;
    slot_waddr     = p_r;
    slot_wdata     = {1'b1, uidx};
    slot_raddr     = p_step;
    name_we        = 1'b0;
    name_waddr     = uidx;
    name_raddr     = slot_entry;
    cmd_nxt        = cmd_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    clr_nxt        = clr_r;
    entry_nxt      = entry_r;
    ucnt_nxt       = ucnt_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_ok_nxt     = res_ok_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_user_nxt   = out_user_r;
    out_offset_nxt = out_offset_r;

    unique case (state_r)
      shl_pkg::BK_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        clr_nxt    = clr_r + SLOT_W'(1);
      end
      shl_pkg::BK_IDLE: begin
        if (!empty) begin
          pop            = 1'b1;
          cmd_nxt        = cmd;
          p_nxt          = cmd.start[SLOT_W-1:0];
          n_nxt          = '0;
          res_status_nxt = shl_pkg::ST_OVERFLOW;
          res_ok_nxt     = 1'b0;
        end
      end
      shl_pkg::BK_PROBE: begin
        if (n_r == PCNT_W'(TABLE_SIZE)) begin
          res_status_nxt = shl_pkg::ST_EXHAUSTED;
          res_ok_nxt     = 1'b0;
        end else begin
          p_nxt = p_step;
          n_nxt = n_r + PCNT_W'(1);
        end
      end
      shl_pkg::BK_SLOT: begin
        if (!slot_used) begin
          if (cmd_r.kind == shl_pkg::CMD_PERM) begin
            name_we        = 1'b1;
            name_waddr     = perm_idx;
            slot_we        = 1'b1;
            slot_wdata     = {1'b1, perm_idx};
            res_status_nxt = shl_pkg::ST_ADDED;
            res_idx_nxt    = perm_idx;
            res_ok_nxt     = 1'b1;
          end else if (room) begin
            name_we        = 1'b1;
            slot_we        = 1'b1;
            ucnt_nxt       = ucnt_r + UCNT_W'(1);
            res_status_nxt = shl_pkg::ST_ADDED;
            res_idx_nxt    = uidx;
            res_ok_nxt     = 1'b1;
          end else begin
            res_status_nxt = shl_pkg::ST_OVERFLOW;
            res_ok_nxt     = 1'b0;
          end
        end else begin
          entry_nxt = slot_entry;
        end
      end
      shl_pkg::BK_CMP: begin
        if (name_rdata == cmd_r.name) begin
          res_status_nxt = shl_pkg::ST_FOUND;
          res_idx_nxt    = entry_r;
          res_ok_nxt     = 1'b1;
        end
      end
      shl_pkg::BK_APPEND: begin
        if (room) begin
          name_we        = 1'b1;
          ucnt_nxt       = ucnt_r + UCNT_W'(1);
          res_status_nxt = shl_pkg::ST_ADDED;
          res_idx_nxt    = uidx;
          res_ok_nxt     = 1'b1;
        end else begin
          res_status_nxt = shl_pkg::ST_OVERFLOW;
          res_ok_nxt     = 1'b0;
        end
      end
      shl_pkg::BK_DONE: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_ok_r ? IDX_W'(res_idx_r) : '0;
          out_user_nxt   = res_ok_r && in_user;
          if (!res_ok_r) begin
            out_offset_nxt = '0;
          end else if (in_user) begin
            out_offset_nxt = IDX_W'(ix_ext - us_ext);
          end else begin
            out_offset_nxt = IDX_W'(ix_ext);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shl_pkg::BK_CLEAR;
      clr_r       <= '0;
      ucnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ucnt_r      <= ucnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    entry_r      <= entry_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_ok_r     <= res_ok_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_user_r   <= out_user_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.symbol_index  = out_index_r;
  assign out_chan.is_user       = out_user_r;
  assign out_chan.region_offset = out_offset_r;

endmodule

// File: bench/tb_symbol_hash_lookup_insert_top.sv
`timescale 1ns / 1ps

module tb_symbol_hash_lookup_insert_top;

  // Block configuration; the bench keeps its own copy for the predictor.
  localparam int TABLE_SIZE  = 1553;
  localparam int USER_LIMIT  = 1500;
  localparam int ENTRY_COUNT = 2048;

  // Opcode 3 has no meaning and must come back as an overflow.
  localparam logic [shl_pkg::OP_W-1:0] OP_NONE = 2'd3;

  localparam int POOL_DEPTH    = 32;
  localparam int SETTLE_CYCLES = 32;
  localparam int WATCHDOG_NS   = 200_000_000;

  typedef struct packed {
    logic [shl_pkg::STATUS_W-1:0] status;
    logic [shl_pkg::IDX_W-1:0]    symbol_index;
    logic                         is_user;
    logic [shl_pkg::IDX_W-1:0]    region_offset;
  } symbol_result_t;

  typedef struct packed {
    logic [shl_pkg::OP_W-1:0]   op;
    logic [shl_pkg::NAME_W-1:0] name;
    logic [shl_pkg::IDX_W-1:0]  entry_index;
    bit                         typed;
    symbol_result_t             result;
  } directed_row_t;

  typedef enum {PROBE_MATCH, PROBE_EMPTY, PROBE_EXHAUSTED} probe_outcome_t;
  typedef enum {RX_STEADY, RX_CHOPPY, RX_SLUGGISH} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [shl_pkg::CFG_W-1:0] cfg_wdata;

  shl_in_if  in_if ();
  shl_out_if out_if ();

  symbol_hash_lookup_insert_top #(
    .TABLE_SIZE  (TABLE_SIZE),
    .USER_LIMIT  (USER_LIMIT),
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: the bench's own copy of the symbol table.
  // ---------------------------------------------------------------------
  logic [shl_pkg::SLOT_MAX_W-1:0] slot_entry [TABLE_SIZE];
  bit                             slot_used  [TABLE_SIZE];
  logic [shl_pkg::NAME_W-1:0]     name_store [ENTRY_COUNT];
  int                             user_count;
  logic [shl_pkg::CFG_W-1:0]      user_start_cfg;

  // Results still owed by the block, oldest first.
  symbol_result_t pending_symbols [$];
  int error_count = 0;

  // Names are cut at their first zero byte; everything above it is ignored
  // for hashing, storing and comparing.
  function automatic logic [shl_pkg::NAME_W-1:0] trim_name(logic [shl_pkg::NAME_W-1:0] nm);
    logic [shl_pkg::NAME_W-1:0] keep;
    bit stop;
    int i;
    keep = '0;
    stop = 1'b0;
    for (i = 0; i < 8; i++) begin
      if (nm[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) keep[8*i +: 8] = nm[8*i +: 8];
    end
    return keep;
  endfunction

  // Running 16-bit sum of the name bytes, with the two halves swapped after
  // every add.
  function automatic logic [shl_pkg::HASH_W-1:0] name_hash(logic [shl_pkg::NAME_W-1:0] nm);
    logic [shl_pkg::HASH_W-1:0] h;
    bit stop;
    int i;
    h = '0;
    stop = 1'b0;
    for (i = 0; i < 8; i++) begin
      if (nm[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) begin
        h = h + {8'd0, nm[8*i +: 8]};
        h = {h[7:0], h[15:8]};
      end
    end
    return h;
  endfunction

  // Walks the probe sequence. The step is taken before each slot check, so
  // a zero step keeps revisiting the start slot until the bound runs out.
  task automatic probe_slots(input logic [shl_pkg::NAME_W-1:0] nm, input bit compare,
                             output probe_outcome_t outcome, output int slot);
    int hv;
    int p;
    int step;
    int n;
    bit done;
    hv = int'(name_hash(nm));
    p = hv % TABLE_SIZE;
    step = (hv / TABLE_SIZE) % TABLE_SIZE;
    outcome = PROBE_EXHAUSTED;
    slot = 0;
    done = 1'b0;
    for (n = 0; n < TABLE_SIZE && !done; n++) begin
      p = (p + TABLE_SIZE - step) % TABLE_SIZE;
      if (!slot_used[p]) begin
        outcome = PROBE_EMPTY;
        slot = p;
        done = 1'b1;
      end else if (compare && name_store[slot_entry[p][shl_pkg::IDX_W-1:0]] == nm) begin
        outcome = PROBE_MATCH;
        slot = p;
        done = 1'b1;
      end
    end
  endtask

  // Next free user entry, if the user area still has room.
  function automatic bit user_room(output int idx);
    idx = 0;
    if (user_count >= USER_LIMIT) return 1'b0;
    if (int'(user_start_cfg) + user_count >= ENTRY_COUNT) return 1'b0;
    idx = int'(user_start_cfg) + user_count;
    return 1'b1;
  endfunction

  // Applies one request to the predictor state and returns its result.
  task automatic predict_symbol(input logic [shl_pkg::OP_W-1:0] op,
                                input logic [shl_pkg::NAME_W-1:0] raw,
                                input logic [shl_pkg::IDX_W-1:0] eidx,
                                output symbol_result_t res);
    logic [shl_pkg::NAME_W-1:0] nm;
    logic [shl_pkg::STATUS_W-1:0] st;
    probe_outcome_t outcome;
    int slot;
    int idx;
    bit ok;
    nm = trim_name(raw);
    st = shl_pkg::ST_OVERFLOW;
    idx = 0;
    ok = 1'b0;
    case (op)
      shl_pkg::OP_FIND: begin
        probe_slots(nm, 1'b1, outcome, slot);
        if (outcome == PROBE_MATCH) begin
          st = shl_pkg::ST_FOUND;
          idx = int'(slot_entry[slot][shl_pkg::IDX_W-1:0]);
          ok = 1'b1;
        end else if (outcome == PROBE_EXHAUSTED) begin
          st = shl_pkg::ST_EXHAUSTED;
        end else if (user_room(idx)) begin
          name_store[idx] = nm;
          user_count++;
          slot_entry[slot] = shl_pkg::SLOT_MAX_W'(idx);
          slot_used[slot] = 1'b1;
          st = shl_pkg::ST_ADDED;
          ok = 1'b1;
        end
      end
      shl_pkg::OP_APPEND: begin
        if (user_room(idx)) begin
          name_store[idx] = nm;
          user_count++;
          st = shl_pkg::ST_ADDED;
          ok = 1'b1;
        end
      end
      shl_pkg::OP_PERM: begin
        if (eidx < ENTRY_COUNT) begin
          probe_slots(nm, 1'b0, outcome, slot);
          if (outcome == PROBE_EMPTY) begin
            name_store[eidx] = nm;
            slot_entry[slot] = shl_pkg::SLOT_MAX_W'(eidx);
            slot_used[slot] = 1'b1;
            idx = int'(eidx);
            st = shl_pkg::ST_ADDED;
            ok = 1'b1;
          end else begin
            st = shl_pkg::ST_EXHAUSTED;
          end
        end
      end
      default: st = shl_pkg::ST_OVERFLOW;
    endcase
    res.status = st;
    res.symbol_index = ok ? shl_pkg::IDX_W'(idx) : '0;
    res.is_user = ok && (idx >= int'(user_start_cfg));
    if (!ok) res.region_offset = '0;
    else if (idx >= int'(user_start_cfg))
      res.region_offset = shl_pkg::IDX_W'(idx - int'(user_start_cfg));
    else res.region_offset = shl_pkg::IDX_W'(idx);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  logic [shl_pkg::NAME_W-1:0] name_pool [POOL_DEPTH];
  int burst_left = 0;

  // A well-formed name: one to eight nonzero bytes, zero padded. An empty
  // name shows up now and then too.
  function automatic logic [shl_pkg::NAME_W-1:0] fresh_name();
    logic [shl_pkg::NAME_W-1:0] nm;
    int len;
    int i;
    nm = '0;
    len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
    for (i = 0; i < len; i++) nm[8*i +: 8] = 8'($urandom_range(1, 255));
    return nm;
  endfunction

  // Fills the bytes above the terminating zero with junk, which the block
  // must ignore.
  function automatic logic [shl_pkg::NAME_W-1:0] add_trailing_junk(
      logic [shl_pkg::NAME_W-1:0] nm);
    logic [shl_pkg::NAME_W-1:0] noisy;
    int len;
    int i;
    noisy = trim_name(nm);
    len = 0;
    for (i = 0; i < 8; i++) if (noisy[8*i +: 8] != 8'h00) len = i + 1;
    for (i = len + 1; i < 8; i++) noisy[8*i +: 8] = 8'($urandom_range(0, 255));
    return noisy;
  endfunction

  // Presents one request and holds it until the block takes it. The sender
  // works in bursts; a fresh burst may start after an idle gap.
  task automatic send_request(input logic [shl_pkg::OP_W-1:0] op,
                              input logic [shl_pkg::NAME_W-1:0] nm,
                              input logic [shl_pkg::IDX_W-1:0] eidx, input bit typed,
                              input symbol_result_t typed_result);
    symbol_result_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.name <= nm;
    in_if.entry_index <= eidx;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    // The request was taken at this edge, so the predictor moves now.
    predict_symbol(op, nm, eidx, res);
    pending_symbols.push_back(typed ? typed_result : res);
  endtask

  // Mostly lookups of names that recur through a small pool, so that found
  // results are common, mixed with fresh names, appends, permanent entries,
  // the meaningless opcode, step-zero names and names with junk bytes.
  task automatic random_request();
    logic [shl_pkg::OP_W-1:0] op;
    logic [shl_pkg::NAME_W-1:0] nm;
    logic [shl_pkg::IDX_W-1:0] eidx;
    int pick;
    pick = $urandom_range(0, 99);
    eidx = shl_pkg::IDX_W'($urandom_range(0, ENTRY_COUNT - 1));
    nm = name_pool[$urandom_range(0, POOL_DEPTH - 1)];
    if ($urandom_range(0, 19) == 0) name_pool[$urandom_range(0, POOL_DEPTH - 1)] = fresh_name();
    if (pick < 50) begin
      op = shl_pkg::OP_FIND;
    end else if (pick < 62) begin
      op = shl_pkg::OP_FIND;
      nm = fresh_name();
    end else if (pick < 72) begin
      op = shl_pkg::OP_APPEND;
      if ($urandom_range(0, 1) == 1) nm = fresh_name();
    end else if (pick < 86) begin
      op = shl_pkg::OP_PERM;
      if ($urandom_range(0, 1) == 1) nm = fresh_name();
      // Permanent entries normally sit below the user area.
      if (user_start_cfg != 0 && $urandom_range(0, 3) != 0)
        eidx = shl_pkg::IDX_W'($urandom_range(0, user_start_cfg - 1));
    end else if (pick < 89) begin
      op = OP_NONE;
      nm = {$urandom, $urandom};
    end else if (pick < 93) begin
      // Single bytes 1 to 6 hash below the table size, so their step is zero.
      op = ($urandom_range(0, 1) == 1) ? shl_pkg::OP_FIND : shl_pkg::OP_PERM;
      nm = shl_pkg::NAME_W'($urandom_range(1, 6));
    end else begin
      op = shl_pkg::OP_FIND;
      nm = add_trailing_junk(nm);
    end
    send_request(op, nm, eidx, 1'b0, '0);
  endtask

  // Drops valid and waits until every owed result is back, plus a margin.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_user_start(input logic [shl_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    user_start_cfg = value;
  endtask

  function automatic directed_row_t row(logic [shl_pkg::OP_W-1:0] op,
                                        logic [shl_pkg::NAME_W-1:0] nm,
                                        logic [shl_pkg::IDX_W-1:0] eidx, bit typed,
                                        logic [shl_pkg::STATUS_W-1:0] st,
                                        logic [shl_pkg::IDX_W-1:0] idx,
                                        logic usr, logic [shl_pkg::IDX_W-1:0] off);
    directed_row_t r;
    r.op = op;
    r.name = nm;
    r.entry_index = eidx;
    r.typed = typed;
    r.result.status = st;
    r.result.symbol_index = idx;
    r.result.is_user = usr;
    r.result.region_offset = off;
    return r;
  endfunction

  localparam int DIRECTED_ROWS = 20;
  directed_row_t directed_rows [DIRECTED_ROWS];

  // ---------------------------------------------------------------------
  // Receiver: ready follows a randomly chosen pattern, held for a random run,
  // from always ready to long stalls.
  // ---------------------------------------------------------------------
  rx_mode_t rx_mode = RX_STEADY;
  int rx_run = 0;

  always @(posedge clk) begin
    if (rx_run == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_run <= $urandom_range(16, 160);
    end else begin
      rx_run <= rx_run - 1;
    end
    case (rx_mode)
      RX_STEADY:  out_if.ready <= 1'b1;
      RX_CHOPPY:  out_if.ready <= 1'($urandom_range(0, 1));
      default:    out_if.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted result is compared with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    symbol_result_t exp_res;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_symbols.size() == 0) begin
        $error("unexpected result: status %0d symbol_index %0d", out_if.status,
               out_if.symbol_index);
        error_count++;
      end else begin
        exp_res = pending_symbols.pop_front();
        if (out_if.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_if.status);
          error_count++;
        end
        if (out_if.symbol_index !== exp_res.symbol_index) begin
          $error("symbol_index: expected %0d, actual %0d", exp_res.symbol_index,
                 out_if.symbol_index);
          error_count++;
        end
        if (out_if.is_user !== exp_res.is_user) begin
          $error("is_user: expected %0d, actual %0d", exp_res.is_user, out_if.is_user);
          error_count++;
        end
        if (out_if.region_offset !== exp_res.region_offset) begin
          $error("region_offset: expected %0d, actual %0d", exp_res.region_offset,
                 out_if.region_offset);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.op = shl_pkg::OP_FIND;
    in_if.name = '0;
    in_if.entry_index = '0;

    for (i = 0; i < TABLE_SIZE; i++) begin
      slot_entry[i] = '0;
      slot_used[i] = 1'b0;
    end
    for (i = 0; i < ENTRY_COUNT; i++) name_store[i] = '0;
    user_count = 0;
    user_start_cfg = '0;
    for (i = 0; i < POOL_DEPTH; i++) name_pool[i] = fresh_name();

    // Directed requests, all with the user area starting at entry 0. Rows
    // whose result is plain from the table state are typed in; the rest are
    // left to the predictor.
    directed_rows[0]  = row(shl_pkg::OP_FIND, 64'h0, 11'd0, 1'b1,
                            shl_pkg::ST_ADDED, 11'd0, 1'b1, 11'd0);
    directed_rows[1]  = row(shl_pkg::OP_FIND, 64'h0, 11'd0, 1'b1,
                            shl_pkg::ST_FOUND, 11'd0, 1'b1, 11'd0);
    directed_rows[2]  = row(shl_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 11'd2047, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    directed_rows[3]  = row(shl_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    // Junk above the first zero byte must not change the name.
    directed_rows[4]  = row(shl_pkg::OP_FIND, 64'hDEAD_BEEF_0000_4142, 11'd0, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    directed_rows[5]  = row(shl_pkg::OP_FIND, 64'h0000_0000_0000_4142, 11'd0, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    directed_rows[6]  = row(shl_pkg::OP_APPEND, 64'h4142, 11'd0, 1'b1,
                            shl_pkg::ST_ADDED, 11'd3, 1'b1, 11'd3);
    directed_rows[7]  = row(OP_NONE, 64'h0, 11'd0, 1'b1,
                            shl_pkg::ST_OVERFLOW, 11'd0, 1'b0, 11'd0);
    directed_rows[8]  = row(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 11'd2047, 1'b1,
                            shl_pkg::ST_OVERFLOW, 11'd0, 1'b0, 11'd0);
    // A one-byte name below 7 hashes under the table size: zero step.
    directed_rows[9]  = row(shl_pkg::OP_PERM, 64'h01, 11'd2047, 1'b1,
                            shl_pkg::ST_ADDED, 11'd2047, 1'b1, 11'd2047);
    // Entering it again finds its only slot taken, so the probes run out.
    directed_rows[10] = row(shl_pkg::OP_PERM, 64'h01, 11'd5, 1'b1,
                            shl_pkg::ST_EXHAUSTED, 11'd0, 1'b0, 11'd0);
    // A different name with the same zero-step hash collides with it.
    directed_rows[11] = row(shl_pkg::OP_FIND, 64'h81_FF80, 11'd0, 1'b1,
                            shl_pkg::ST_EXHAUSTED, 11'd0, 1'b0, 11'd0);
    directed_rows[12] = row(shl_pkg::OP_FIND, 64'h01, 11'd0, 1'b1,
                            shl_pkg::ST_FOUND, 11'd2047, 1'b1, 11'd2047);
    // A permanent entry at index 0 overwrites the stored empty name.
    directed_rows[13] = row(shl_pkg::OP_PERM, 64'h4443_4241, 11'd0, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    directed_rows[14] = row(shl_pkg::OP_FIND, 64'h0, 11'd0, 1'b1,
                            shl_pkg::ST_EXHAUSTED, 11'd0, 1'b0, 11'd0);
    directed_rows[15] = row(shl_pkg::OP_FIND, 64'h4443_4241, 11'd0, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    directed_rows[16] = row(shl_pkg::OP_FIND, 64'h0102_0304_0506_0708, 11'd0, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    // Zero low byte: the name is empty, whatever the upper bytes hold.
    directed_rows[17] = row(shl_pkg::OP_FIND, 64'h8000_0000_0000_0000, 11'd0, 1'b1,
                            shl_pkg::ST_EXHAUSTED, 11'd0, 1'b0, 11'd0);
    directed_rows[18] = row(shl_pkg::OP_APPEND, 64'h7F, 11'd0, 1'b0,
                            shl_pkg::ST_FOUND, '0, 1'b0, '0);
    directed_rows[19] = row(shl_pkg::OP_PERM, 64'hFFFF_FFFF_FFFF_FF00, 11'd1024, 1'b1,
                            shl_pkg::ST_EXHAUSTED, 11'd0, 1'b0, 11'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its slots after reset but takes the register write.
    write_user_start(10'd0);
    for (i = 0; i < DIRECTED_ROWS; i++)
      send_request(directed_rows[i].op, directed_rows[i].name, directed_rows[i].entry_index,
                   directed_rows[i].typed, directed_rows[i].result);

    // Random phases under different user area bases, the extremes included.
    settle();
    write_user_start(10'd547);
    repeat (300) random_request();

    settle();
    write_user_start(shl_pkg::CFG_W'($urandom_range(1, 546)));
    repeat (300) random_request();

    settle();
    write_user_start(10'd0);
    repeat (250) random_request();

    settle();
    if (error_count == 0) begin
      $display("tb_symbol_hash_lookup_insert_top: PASS");
    end else begin
      $display("tb_symbol_hash_lookup_insert_top: FAIL");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #(WATCHDOG_NS);
    $display("tb_symbol_hash_lookup_insert_top: FAIL");
    $finish;
  end

endmodule

// File: files.f
src/shl_pkg.sv
src/shl_in_if.sv
src/shl_out_if.sv
src/shl_ram.sv
src/shl_front.sv
src/shl_cmd_queue.sv
src/shl_back.sv
src/symbol_hash_lookup_insert_top.sv
bench/tb_symbol_hash_lookup_insert_top.sv
